[rtl/rvoq_pkg.sv]
// package for the range value occurrence query block
// opcode codes and the scan sequencer state type; no dependencies
package rvoq_pkg;

  localparam int OPCODE_WIDTH = 2;
  localparam int INPUT_WIDTH = 32;
  localparam int POS_WIDTH = 17;

  localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_QUERY = 2'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_RESERVED = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } result_t;

endpackage

[rtl/rvoq_store.sv]
// value memory of the range value occurrence query block
// one write port and one registered read port; uses no package
module rvoq_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32,
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/range_value_occurrence_query.sv]
// Range value occurrence query: holds values at positions 1..count. An append passes through
// ST_OUT to its result in ST_WAIT; a clear or a reserved opcode returns nothing. A query walks
// the clipped range one position at a time (read, then compare) through the single memory
// read port and one shared comparator, stopping at the first match; an empty range goes
// straight to the result. After an append or a query the block takes a new item only after
// the result has been taken.
// Depends on rvoq_pkg and rvoq_store.
module range_value_occurrence_query #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[1:0], item_value[33:2], range_low[50:34], range_high[67:51], zero fill
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found[0], overflow[1], zero fill
  output logic [7:0]  m_tdata
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = (CW > rvoq_pkg::POS_WIDTH) ? CW : rvoq_pkg::POS_WIDTH;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

  rvoq_pkg::state_t state;
  logic [CW-1:0] count;
  logic [PW-1:0] pos;
  logic [PW-1:0] last;
  logic [VALUE_WIDTH-1:0] key;
  rvoq_pkg::result_t res;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic [rvoq_pkg::OPCODE_WIDTH-1:0] opcode;
  logic [rvoq_pkg::INPUT_WIDTH-1:0] item_value;
  logic [rvoq_pkg::POS_WIDTH-1:0] range_low, range_high;
  logic [PW-1:0] lo_clip, hi_clip;
  logic accept, wr_en;

  assign opcode = s_tdata[1:0];
  assign item_value = s_tdata[33:2];
  assign range_low = s_tdata[50:34];
  assign range_high = s_tdata[67:51];
  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == rvoq_pkg::ST_IDLE);
  assign m_tvalid = (state == rvoq_pkg::ST_WAIT);
  assign m_tdata = {6'd0, res.overflow, res.found};

  // range clipping
  always_comb begin
    lo_clip = (range_low == '0) ? PW'(1) : PW'(range_low);
    hi_clip = (PW'(range_high) > PW'(count)) ? PW'(count) : PW'(range_high);
  end

  assign wr_en = accept && (opcode == rvoq_pkg::OP_APPEND) && (count < MaxCount);

  rvoq_store #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_WIDTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (VALUE_WIDTH'(item_value)),
    .rd_addr (AW'(pos - PW'(1))),
    .rd_data (rd_data)
  );

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvoq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        rvoq_pkg::ST_IDLE: begin
          if (accept) begin
            key <= VALUE_WIDTH'(item_value);
            res <= '0;
            pos <= lo_clip;
            last <= hi_clip;
            case (opcode)
              rvoq_pkg::OP_CLEAR: count <= '0;
              rvoq_pkg::OP_APPEND: begin
                if (count < MaxCount) count <= count + CW'(1);
                else res.overflow <= 1'b1;
                state <= rvoq_pkg::ST_OUT;
              end
              rvoq_pkg::OP_QUERY: begin
                state <= (lo_clip > hi_clip) ? rvoq_pkg::ST_OUT : rvoq_pkg::ST_READ;
              end
              default: state <= rvoq_pkg::ST_IDLE;
            endcase
          end
        end
        rvoq_pkg::ST_READ: state <= rvoq_pkg::ST_CMP;
        rvoq_pkg::ST_CMP: begin
          if (rd_data == key) begin
            res.found <= 1'b1;
            state <= rvoq_pkg::ST_OUT;
          end else if (pos == last) begin
            state <= rvoq_pkg::ST_OUT;
          end else begin
            pos <= pos + PW'(1);
            state <= rvoq_pkg::ST_READ;
          end
        end
        rvoq_pkg::ST_OUT: state <= rvoq_pkg::ST_WAIT;
        rvoq_pkg::ST_WAIT: if (m_tready) state <= rvoq_pkg::ST_IDLE;
        default: state <= rvoq_pkg::ST_IDLE;
      endcase
    end
  end

  // checks
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.found && res.overflow)) else $error("found and overflow both set");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCount) else $error("count past capacity");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rvoq_pkg::ST_CMP) |-> (pos <= last)) else $error("scan past range end");

endmodule
